FILE: rtl/pwg_pkg.sv
// Shared types and constants for the periodic waveform generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pwg_pkg;

   localparam int unsigned LOWEST_TONE_HZ       = 100;
   localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

   localparam int unsigned FIELD_W  = 20;
   localparam int unsigned SAMPLE_W = 8;

   localparam logic [SAMPLE_W-1:0] BIAS_LEVEL = 8'h80;
   localparam logic [SAMPLE_W-1:0] AMPL_LEVEL = 8'h7F;
   localparam logic [SAMPLE_W-1:0] LOW_LEVEL  = 8'h01;
   localparam logic [SAMPLE_W-1:0] HIGH_LEVEL = 8'hFF;

   localparam logic [FIELD_W-1:0] RATE_RESET = 20'd48000;
   localparam logic [FIELD_W-1:0] TONE_RESET = 20'd440;

   localparam logic [1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] CSR_TONE_FREQ   = 2'd1;
   localparam logic [1:0] CSR_WAVEFORM    = 2'd2;

   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_SQUARE   = 2'd1;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
   localparam logic [1:0] WAVE_SAW      = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage : pwg_pkg

`default_nettype wire

FILE: rtl/pwg_divider.sv
// Bit-serial restoring divider: one quotient bit per clock.
// Depends on pwg_pkg for the field width and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module pwg_divider
   import pwg_pkg::*;
#(
   parameter int unsigned DIV_W = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_W-1:0]    dividend,
   input  wire logic [FIELD_W-1:0]  divisor,
   output div_status_type           status,
   output logic      [DIV_W-1:0]    quotient
);

   localparam int unsigned CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [FIELD_W-1:0] rem_ff, rem_in;
   logic [FIELD_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [FIELD_W:0]   trial;
   logic               fits;

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? FIELD_W'(trial - {1'b0, dsr_ff}) : trial[FIELD_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule : pwg_divider

`default_nettype wire

FILE: rtl/pwg_sine_rom.sv
// Quarter-wave sine ROM with registered read, built at elaboration.
// Each entry holds floor and ceiling of 127*m/32767 for magnitude m.
`timescale 1ns / 1ps
`default_nettype none

module pwg_sine_rom
   import pwg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int unsigned ADDR_W           = $clog2(SINE_TABLE_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] addr,
   output logic      [6:0]        floor_part,
   output logic      [6:0]        ceil_part
);

   typedef logic [13:0] rom_type [0:SINE_TABLE_DEPTH];

   // Q30 Taylor series of sin, rounded to Q15 and saturated.
   function automatic logic [13:0] rom_entry(input int k);
      logic [63:0] x;
      logic [63:0] term;
      logic signed [64:0] acc;
      logic [63:0] mag;
      logic [63:0] fl;
      logic [63:0] cl;
      x    = (64'd1686629713 * 64'(k)) / SINE_TABLE_DEPTH;
      term = x;
      acc  = 65'(x);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd6;   acc = acc - 65'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd20;  acc = acc + 65'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd42;  acc = acc - 65'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd72;  acc = acc + 65'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd110; acc = acc - 65'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd156; acc = acc + 65'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd210; acc = acc - 65'(term);
      if (acc < 0) begin
         acc = '0;
      end
      mag = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      fl = (mag * 64'd127) / 64'd32767;
      cl = (mag * 64'd127 + 64'd32766) / 64'd32767;
      return {cl[6:0], fl[6:0]};
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k <= int'(SINE_TABLE_DEPTH); k++) begin
         t[k] = rom_entry(k);
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [13:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= ROM[addr];
   end

   assign floor_part = data_ff[6:0];
   assign ceil_part  = data_ff[13:7];

endmodule : pwg_sine_rom

`default_nettype wire

FILE: rtl/periodic_waveform_generator.sv
// Periodic waveform generator top level: control sequencer and ports.
// Depends on pwg_pkg, pwg_divider and pwg_sine_rom.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted request yields one 8-bit unsigned DAC sample of a sine, square,
// triangle or sawtooth wave. A request with restart set latches the period as
// sample_rate / tone_frequency, checks the settings and returns the phase to
// zero; the rate and frequency registers only take effect at a restart, while
// the waveform register is used live. All divisions run on one bit-serial
// restoring divider of DIV_W bits (DIV_W is 32 for a 1024-entry sine table),
// one quotient bit per clock. A square sample needs no division, a triangle or
// sawtooth sample needs one, and a sine sample needs one followed by a read
// of the registered table; the sample reaches the output register as the
// sequencer returns to idle, where the next request can be taken. A restart
// with usable rate and frequency adds the period division. Requests are taken
// one at a time, but the next request is accepted while a finished sample
// still waits in the output register; a second finished sample holds the
// sequencer until the first one is taken. Invalid settings give sample 128
// with the error flag in tuser. Configuration writes are always ready.

module periodic_waveform_generator
   import pwg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // [0] restart, [7:1] zero
   // Sample channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [7:0]   rsp_tdata,    // [7:0] sample
   output logic              rsp_tlast,    // period_last
   output logic              rsp_tuser,    // [0] config_error
   // Register writes.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [19:0]  csr_wdata
);

   localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int unsigned SINE_W = FIELD_W + $clog2(4 * SINE_TABLE_DEPTH);
   localparam int unsigned DIV_W  = (SINE_W > 28) ? SINE_W : 28;

   localparam logic [DIV_W-1:0] DEPTH_1 = DIV_W'(SINE_TABLE_DEPTH);
   localparam logic [DIV_W-1:0] DEPTH_2 = DIV_W'(2 * SINE_TABLE_DEPTH);
   localparam logic [DIV_W-1:0] DEPTH_3 = DIV_W'(3 * SINE_TABLE_DEPTH);
   localparam logic [DIV_W-1:0] DEPTH_4 = DIV_W'(4 * SINE_TABLE_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_DIV_PERIOD = 7'b0000010,
      ST_EVAL       = 7'b0000100,
      ST_DIV_WAVE   = 7'b0001000,
      ST_ROM_READ   = 7'b0010000,
      ST_SINE       = 7'b0100000,
      ST_FINISH     = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      SEG_SINE,
      SEG_RISE_HIGH,
      SEG_FALL,
      SEG_RISE_LOW
   } seg_type;

   state_type           state_ff, state_in;
   seg_type             seg_ff, seg_in;

   logic [FIELD_W-1:0]  rate_ff, rate_in;
   logic [FIELD_W-1:0]  tone_ff, tone_in;
   logic [1:0]          wave_ff, wave_in;

   logic [FIELD_W-1:0]  phase_ff, phase_in;
   logic [FIELD_W-1:0]  period_ff, period_in;
   logic                valid_ff, valid_in;

   logic [SAMPLE_W-1:0] res_sample_ff, res_sample_in;
   logic                res_last_ff, res_last_in;
   logic                res_err_ff, res_err_in;

   logic [ADDR_W-1:0]   rom_addr_ff, rom_addr_in;
   logic                neg_ff, neg_in;

   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                out_last_ff, out_last_in;
   logic                out_err_ff, out_err_in;

   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [FIELD_W-1:0]  div_divisor;
   div_status_type      div_status;
   logic [DIV_W-1:0]    div_quotient;

   logic [6:0]          rom_floor;
   logic [6:0]          rom_ceil;

   logic [FIELD_W-1:0]  quarter;
   logic [FIELD_W-1:0]  half;
   logic [FIELD_W-1:0]  three_q;
   logic [FIELD_W:0]    phase_plus;
   logic                is_last;
   logic [ADDR_W-1:0]   rem_idx;

   assign quarter    = period_ff >> 2;
   assign half       = period_ff >> 1;
   assign three_q    = FIELD_W'(({2'b00, period_ff} + {1'b0, period_ff, 1'b0}) >> 2);
   assign phase_plus = {1'b0, phase_ff} + 21'd1;
   assign is_last    = phase_plus == {1'b0, period_ff};

   // Register writes: an index past the list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      rate_in = rate_ff;
      tone_in = tone_ff;
      wave_in = wave_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_RATE: rate_in = csr_wdata;
            CSR_TONE_FREQ:   tone_in = csr_wdata;
            CSR_WAVEFORM:    wave_in = csr_wdata[1:0];
            default:         ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      seg_in        = seg_ff;
      phase_in      = phase_ff;
      period_in     = period_ff;
      valid_in      = valid_ff;
      res_sample_in = res_sample_ff;
      res_last_in   = res_last_ff;
      res_err_in    = res_err_ff;
      rom_addr_in   = rom_addr_ff;
      neg_in        = neg_ff;
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;
      div_start     = 1'b0;
      div_dividend  = DIV_W'(rate_ff);
      div_divisor   = tone_ff;
      rem_idx       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  phase_in  = '0;
                  period_in = '0;
                  valid_in  = 1'b0;
                  if (({1'b0, rate_ff} >= 21'(2 * LOWEST_TONE_HZ)) &&
                      (tone_ff >= FIELD_W'(LOWEST_TONE_HZ))) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV_PERIOD;
                  end else begin
                     state_in = ST_EVAL;
                  end
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end

         ST_DIV_PERIOD: begin
            if (div_status.done) begin
               period_in = div_quotient[FIELD_W-1:0];
               valid_in  = div_quotient[FIELD_W-1:0] >= FIELD_W'(4);
               state_in  = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (!valid_ff || (period_ff < FIELD_W'(4)) || (phase_ff >= period_ff)) begin
               phase_in      = '0;
               res_sample_in = BIAS_LEVEL;
               res_last_in   = 1'b0;
               res_err_in    = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               res_last_in = is_last;
               res_err_in  = 1'b0;
               phase_in    = is_last ? '0 : phase_plus[FIELD_W-1:0];
               state_in    = ST_DIV_WAVE;
               div_start   = 1'b1;
               case (wave_ff)
                  WAVE_SINE: begin
                     seg_in       = SEG_SINE;
                     div_dividend = DIV_W'(phase_ff) * DEPTH_4;
                     div_divisor  = period_ff;
                  end
                  WAVE_SQUARE: begin
                     div_start     = 1'b0;
                     res_sample_in = (phase_ff < half) ? HIGH_LEVEL : LOW_LEVEL;
                     state_in      = ST_FINISH;
                  end
                  WAVE_TRIANGLE: begin
                     div_divisor = quarter;
                     if (phase_ff < quarter) begin
                        seg_in       = SEG_RISE_HIGH;
                        div_dividend = (DIV_W'(phase_ff) << 7) - DIV_W'(phase_ff);
                     end else if (phase_ff < three_q) begin
                        seg_in       = SEG_FALL;
                        div_dividend = (DIV_W'(phase_ff - quarter) << 7)
                                     - DIV_W'(phase_ff - quarter)
                                     + DIV_W'(quarter) - DIV_W'(1);
                     end else begin
                        seg_in       = SEG_RISE_LOW;
                        div_dividend = (DIV_W'(phase_ff - three_q) << 7)
                                     - DIV_W'(phase_ff - three_q);
                     end
                  end
                  default: begin
                     div_divisor = half;
                     if (phase_ff < half) begin
                        seg_in       = SEG_RISE_HIGH;
                        div_dividend = (DIV_W'(phase_ff) << 7) - DIV_W'(phase_ff);
                     end else begin
                        seg_in       = SEG_RISE_LOW;
                        div_dividend = (DIV_W'(phase_ff - half) << 7)
                                     - DIV_W'(phase_ff - half);
                     end
                  end
               endcase
            end
         end

         ST_DIV_WAVE: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
               case (seg_ff)
                  SEG_SINE: begin
                     // The table index splits into a quadrant and an offset.
                     state_in = ST_ROM_READ;
                     if (div_quotient < DEPTH_1) begin
                        rem_idx     = div_quotient[ADDR_W-1:0];
                        rom_addr_in = rem_idx;
                        neg_in      = 1'b0;
                     end else if (div_quotient < DEPTH_2) begin
                        rem_idx     = ADDR_W'(div_quotient - DEPTH_1);
                        rom_addr_in = ADDR_W'(SINE_TABLE_DEPTH) - rem_idx;
                        neg_in      = 1'b0;
                     end else if (div_quotient < DEPTH_3) begin
                        rem_idx     = ADDR_W'(div_quotient - DEPTH_2);
                        rom_addr_in = rem_idx;
                        neg_in      = 1'b1;
                     end else begin
                        rem_idx     = ADDR_W'(div_quotient - DEPTH_3);
                        rom_addr_in = ADDR_W'(SINE_TABLE_DEPTH) - rem_idx;
                        neg_in      = 1'b1;
                     end
                  end
                  SEG_RISE_HIGH: begin
                     res_sample_in = BIAS_LEVEL + div_quotient[SAMPLE_W-1:0];
                  end
                  SEG_FALL: begin
                     // The falling edge saturates at zero when it overshoots.
                     if (div_quotient > DIV_W'(255)) begin
                        res_sample_in = '0;
                     end else begin
                        res_sample_in = HIGH_LEVEL - div_quotient[SAMPLE_W-1:0];
                     end
                  end
                  default: begin
                     res_sample_in = LOW_LEVEL + div_quotient[SAMPLE_W-1:0];
                  end
               endcase
            end
         end

         ST_ROM_READ: begin
            state_in = ST_SINE;
         end

         ST_SINE: begin
            res_sample_in = neg_ff ? (BIAS_LEVEL - {1'b0, rom_ceil})
                                   : (BIAS_LEVEL + {1'b0, rom_floor});
            state_in      = ST_FINISH;
         end

         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in  = 1'b1;
               out_sample_in = res_sample_ff;
               out_last_in   = res_last_ff;
               out_err_in    = res_err_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RESET;
         tone_ff      <= TONE_RESET;
         wave_ff      <= WAVE_SINE;
         phase_ff     <= '0;
         period_ff    <= '0;
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         tone_ff      <= tone_in;
         wave_ff      <= wave_in;
         phase_ff     <= phase_in;
         period_ff    <= period_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
      seg_ff        <= seg_in;
      res_sample_ff <= res_sample_in;
      res_last_ff   <= res_last_in;
      res_err_ff    <= res_err_in;
      rom_addr_ff   <= rom_addr_in;
      neg_ff        <= neg_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
      out_err_ff    <= out_err_in;
   end

   pwg_divider #(
      .DIV_W (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   pwg_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .ADDR_W           (ADDR_W)
   ) u_sine_rom (
      .clock      (clock),
      .addr       (rom_addr_ff),
      .floor_part (rom_floor),
      .ceil_part  (rom_ceil)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // An error sample is always the midpoint and never closes a period.
   a_error_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == BIAS_LEVEL && !rsp_tlast))
      else $error("error sample is not the midpoint");

   // Valid settings always carry a usable period.
   a_period_ok: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (period_ff >= FIELD_W'(4)))
      else $error("valid settings with a period below four");

   // The phase stays inside the period while the sequencer is idle with valid settings.
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && state_ff == ST_IDLE) |-> (phase_ff < period_ff))
      else $error("phase outside the period");

   // The divider is only started while it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

endmodule : periodic_waveform_generator

`default_nettype wire
